// ===== hw/rtl/byte_register_vm_execute_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the byte register VM execute block
// Concurrent checks on clk_i with rst_ni held low masking the check.
// ----------------------------------------------------------------------------
`ifndef BYTE_REGISTER_VM_EXECUTE_DEFINES_SVH
`define BYTE_REGISTER_VM_EXECUTE_DEFINES_SVH

`ifndef SYNTHESIS
`define BRV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BRV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BRV_ASSERT(lbl, prop, msg)
`define BRV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/brv_pkg.sv =====
// ----------------------------------------------------------------------------
// brv_pkg
// Shared types and constants of the byte register VM execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package brv_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;

  // Decoupling queue, depth must stay a power of two (pointers wrap)
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;

  localparam logic [11:0] PC_RESET = 12'h200;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SYS     = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_UNHAND  = 3'd3,
    ST_STACK   = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    OP_CLS,
    OP_RET,
    OP_SYS,
    OP_JP,
    OP_CALL,
    OP_SE_IMM,
    OP_SNE_IMM,
    OP_SE_REG,
    OP_SNE_REG,
    OP_LD_IMM,
    OP_ADD_IMM,
    OP_MOV,
    OP_OR,
    OP_AND,
    OP_XOR,
    OP_ADD,
    OP_SUB,
    OP_SHR,
    OP_SUBN,
    OP_SHL,
    OP_LD_IDX,
    OP_JP_V0,
    OP_RND,
    OP_LD_DT,
    OP_SET_DT,
    OP_SET_ST,
    OP_ADD_IDX,
    OP_UNHAND,
    OP_UNKNOWN
  } op_e;

  // Decoded instruction; x = nnn[11:8], y = nnn[7:4]
  typedef struct packed {
    op_e         op;
    logic [11:0] nnn;
    logic [7:0]  imm;
  } brv_uop_t;

  typedef struct packed {
    logic        valid;
    brv_uop_t    uop;
  } brv_qhead_t;

  typedef struct packed {
    logic [11:0] pc_next;
    status_e     status;
    logic        clear_screen;
    logic        reg_write_valid;
    logic [3:0]  reg_write_index;
    logic [7:0]  reg_write_value;
    logic        flag_write_valid;
    logic        flag_value;
    logic [15:0] index_value;
  } brv_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/byte_register_vm_execute.sv =====
// ----------------------------------------------------------------------------
// byte_register_vm_execute
// Executes one 16-bit byte register VM instruction per beat.
// ----------------------------------------------------------------------------
// One instruction per clock is sustained while the output is not stalled:
// the execute stage reads and updates every piece of machine state
// (registers, pc, index, stack, timers), and that stage sets the rate.
// An accepted beat is decoded into a two-entry queue, read from the
// register file as it leaves the queue, executed and registered in the
// result register. Either side may stall without stopping the other
// until the queue fills. The return stack holds STACK_DEPTH entries and
// needs no clearing after reset.
`default_nettype none

module byte_register_vm_execute import brv_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [15:0] opcode, [23:16] random_byte
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [11:0] pc_next, [14:12] status, [15] clear_screen, [16] reg_write_valid,
  // [20:17] reg_write_index, [28:21] reg_write_value, [29] flag_write_valid,
  // [30] flag_value, [46:31] index_value, [47] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  brv_uop_t    dec_uop;
  brv_qhead_t  q_head;
  logic        q_full, q_push, q_pop;
  brv_result_t res;

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  brv_front u_front (
    .opcode_i      (s_axis_tdata[15:0]),
    .random_byte_i (s_axis_tdata[23:16]),
    .uop_o         (dec_uop)
  );

  brv_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .uop_i  (dec_uop),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head)
  );

  brv_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {1'b0, res.index_value, res.flag_value, res.flag_write_valid,
                         res.reg_write_value, res.reg_write_index, res.reg_write_valid,
                         res.clear_screen, res.status, res.pc_next};

endmodule

`default_nettype wire

// ===== hw/rtl/brv_front.sv =====
// ----------------------------------------------------------------------------
// brv_front
// Accepts opcode beats and classifies them into decoded instructions.
// ----------------------------------------------------------------------------
`default_nettype none

module brv_front import brv_pkg::*; (
  input  wire logic [15:0] opcode_i,
  input  wire logic [7:0]  random_byte_i,
  output brv_uop_t         uop_o
);

  logic [3:0] n;
  logic [7:0] kk;

  assign n  = opcode_i[3:0];
  assign kk = opcode_i[7:0];

  always_comb begin
    uop_o.op  = OP_UNKNOWN;
    uop_o.nnn = opcode_i[11:0];
    uop_o.imm = kk;
    unique case (opcode_i[15:12])
      4'h0: begin
        if (opcode_i == 16'h00E0) begin
          uop_o.op = OP_CLS;
        end else if (opcode_i == 16'h00EE) begin
          uop_o.op = OP_RET;
        end else begin
          uop_o.op = OP_SYS;
        end
      end
      4'h1: uop_o.op = OP_JP;
      4'h2: uop_o.op = OP_CALL;
      4'h3: uop_o.op = OP_SE_IMM;
      4'h4: uop_o.op = OP_SNE_IMM;
      4'h5: uop_o.op = (n == 4'h0) ? OP_SE_REG : OP_UNKNOWN;
      4'h6: uop_o.op = OP_LD_IMM;
      4'h7: uop_o.op = OP_ADD_IMM;
      4'h8: begin
        unique case (n)
          4'h0:    uop_o.op = OP_MOV;
          4'h1:    uop_o.op = OP_OR;
          4'h2:    uop_o.op = OP_AND;
          4'h3:    uop_o.op = OP_XOR;
          4'h4:    uop_o.op = OP_ADD;
          4'h5:    uop_o.op = OP_SUB;
          4'h6:    uop_o.op = OP_SHR;
          4'h7:    uop_o.op = OP_SUBN;
          4'hE:    uop_o.op = OP_SHL;
          default: uop_o.op = OP_UNKNOWN;
        endcase
      end
      4'h9: uop_o.op = (n == 4'h0) ? OP_SNE_REG : OP_UNKNOWN;
      4'hA: uop_o.op = OP_LD_IDX;
      4'hB: uop_o.op = OP_JP_V0;
      4'hC: begin
        // mask the random byte here so the back end sees a plain immediate
        uop_o.op  = OP_RND;
        uop_o.imm = random_byte_i & kk;
      end
      4'hD: uop_o.op = OP_UNHAND;
      4'hE: uop_o.op = (kk == 8'h9E || kk == 8'hA1) ? OP_UNHAND : OP_UNKNOWN;
      4'hF: begin
        unique case (kk)
          8'h07:   uop_o.op = OP_LD_DT;
          8'h15:   uop_o.op = OP_SET_DT;
          8'h18:   uop_o.op = OP_SET_ST;
          8'h1E:   uop_o.op = OP_ADD_IDX;
          8'h0A, 8'h29, 8'h33, 8'h55, 8'h65: uop_o.op = OP_UNHAND;
          default: uop_o.op = OP_UNKNOWN;
        endcase
      end
      default: uop_o.op = OP_UNKNOWN;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/brv_queue.sv =====
// ----------------------------------------------------------------------------
// brv_queue
// Short queue of decoded instructions between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module brv_queue import brv_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  brv_uop_t    uop_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output brv_qhead_t  head_o
);

  brv_uop_t            entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     cnt_q, cnt_d;

  assign full_o       = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.uop   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= uop_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/brv_back.sv =====
// ----------------------------------------------------------------------------
// brv_back
// Register read, execute and result register; owns all machine state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_register_vm_execute_defines.svh"

module brv_back import brv_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  brv_qhead_t  head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output brv_result_t out_res_o
);

  localparam int unsigned SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // register file: V0..VE in memory, VF and a copy of V0 in flops
  logic [7:0]  regs_mem [16];
  logic [15:0] reg_vld_q;
  logic [7:0]  rdx_q, rdy_q;
  logic        rdx_vld_q, rdy_vld_q;
  logic [7:0]  v0_q, vf_q;

  // last register write, forwarded over the registered read
  logic        lw_valid_q;
  logic [3:0]  lw_idx_q;
  logic [7:0]  lw_val_q;

  logic [11:0] stk_mem [STACK_DEPTH];
  logic [11:0] tos_q;
  logic [SP_W-1:0] sp_q, sp_d, sp_m1;

  logic [11:0] pc_q;
  logic [15:0] index_q, index_d;
  logic [7:0]  dt_q, dt_d, st_q, st_d;

  logic        e_valid_q;
  brv_uop_t    e_uop_q;
  logic        fire, xfer;

  logic        out_valid_q;
  brv_result_t out_res_q, res;

  logic [3:0]  x, y, hx, hy;
  logic [7:0]  vx, vy, mx, my, imm;
  logic [8:0]  sum9;
  logic [11:0] next_pc;
  logic        rw, fw, fval, stk_push, stk_pop;
  logic [7:0]  rval;
  logic [7:0]  vf_d;

  assign fire  = e_valid_q && (!out_valid_q || out_ready_i);
  assign xfer  = head_i.valid && (!e_valid_q || fire);
  assign pop_o = xfer;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  assign x   = e_uop_q.nnn[11:8];
  assign y   = e_uop_q.nnn[7:4];
  assign imm = e_uop_q.imm;
  assign hx  = head_i.uop.nnn[11:8];
  assign hy  = head_i.uop.nnn[7:4];

  // memory operand: unwritten entries read as zero
  assign mx = rdx_vld_q ? rdx_q : 8'h00;
  assign my = rdy_vld_q ? rdy_q : 8'h00;

  always_comb begin
    if (x == 4'hF) begin
      vx = vf_q;
    end else if (lw_valid_q && lw_idx_q == x) begin
      vx = lw_val_q;
    end else begin
      vx = mx;
    end
    if (y == 4'hF) begin
      vy = vf_q;
    end else if (lw_valid_q && lw_idx_q == y) begin
      vy = lw_val_q;
    end else begin
      vy = my;
    end
  end

  assign sum9 = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    next_pc  = pc_q + 12'd2;
    res      = '0;
    res.status = ST_OK;
    rw       = 1'b0;
    fw       = 1'b0;
    rval     = 8'h00;
    fval     = 1'b0;
    stk_push = 1'b0;
    stk_pop  = 1'b0;
    index_d  = index_q;
    dt_d     = dt_q;
    st_d     = st_q;
    unique case (e_uop_q.op)
      OP_CLS: res.clear_screen = 1'b1;
      OP_RET: begin
        if (sp_q == '0) begin
          res.status = ST_STACK;
        end else begin
          stk_pop = 1'b1;
          next_pc = tos_q + 12'd2;
        end
      end
      OP_SYS:  res.status = ST_SYS;
      OP_JP:   next_pc = e_uop_q.nnn;
      OP_CALL: begin
        if (sp_q >= SP_W'(STACK_DEPTH)) begin
          res.status = ST_STACK;
        end else begin
          stk_push = 1'b1;
          next_pc  = e_uop_q.nnn;
        end
      end
      OP_SE_IMM:  if (vx == imm) next_pc = pc_q + 12'd4;
      OP_SNE_IMM: if (vx != imm) next_pc = pc_q + 12'd4;
      OP_SE_REG:  if (vx == vy)  next_pc = pc_q + 12'd4;
      OP_SNE_REG: if (vx != vy)  next_pc = pc_q + 12'd4;
      OP_LD_IMM, OP_RND: begin
        rw   = 1'b1;
        rval = imm;
      end
      OP_ADD_IMM: begin
        rw   = 1'b1;
        rval = vx + imm;
      end
      OP_MOV: begin
        rw   = 1'b1;
        rval = vy;
      end
      OP_OR: begin
        rw   = 1'b1;
        rval = vx | vy;
      end
      OP_AND: begin
        rw   = 1'b1;
        rval = vx & vy;
      end
      OP_XOR: begin
        rw   = 1'b1;
        rval = vx ^ vy;
      end
      OP_ADD: begin
        rw   = 1'b1;
        fw   = 1'b1;
        rval = sum9[7:0];
        fval = sum9[8];
      end
      OP_SUB: begin
        rw   = 1'b1;
        fw   = 1'b1;
        rval = vx - vy;
        fval = (vx >= vy);
      end
      OP_SHR: begin
        rw   = 1'b1;
        fw   = 1'b1;
        rval = {1'b0, vx[7:1]};
        fval = vx[0];
      end
      OP_SUBN: begin
        rw   = 1'b1;
        fw   = 1'b1;
        rval = vy - vx;
        fval = (vy >= vx);
      end
      OP_SHL: begin
        rw   = 1'b1;
        fw   = 1'b1;
        rval = {vx[6:0], 1'b0};
        fval = vx[7];
      end
      OP_LD_IDX:  index_d = {4'h0, e_uop_q.nnn};
      OP_JP_V0:   next_pc = e_uop_q.nnn + {4'h0, v0_q};
      OP_LD_DT: begin
        rw   = 1'b1;
        rval = dt_q;
      end
      OP_SET_DT:  dt_d = vx;
      OP_SET_ST:  st_d = vx;
      OP_ADD_IDX: index_d = index_q + {8'h00, vx};
      OP_UNHAND:  res.status = ST_UNHAND;
      OP_UNKNOWN: res.status = ST_UNKNOWN;
      default:    res.status = ST_UNKNOWN;
    endcase

    res.pc_next          = next_pc;
    res.reg_write_valid  = rw;
    res.reg_write_index  = rw ? x : 4'h0;
    res.reg_write_value  = rw ? rval : 8'h00;
    res.flag_write_valid = fw;
    res.flag_value       = fw ? fval : 1'b0;
    res.index_value      = index_d;
  end

  // flag is written after the register
  always_comb begin
    vf_d = vf_q;
    if (rw && x == 4'hF) begin
      vf_d = rval;
    end
    if (fw) begin
      vf_d = {7'h00, fval};
    end
  end

  always_comb begin
    sp_d = sp_q;
    if (stk_push) begin
      sp_d = sp_q + SP_W'(1);
    end else if (stk_pop) begin
      sp_d = sp_q - SP_W'(1);
    end
    sp_m1 = sp_d - SP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= PC_RESET;
      index_q     <= '0;
      sp_q        <= '0;
      dt_q        <= '0;
      st_q        <= '0;
      v0_q        <= '0;
      vf_q        <= '0;
      reg_vld_q   <= '0;
      lw_valid_q  <= 1'b0;
    end else begin
      if (xfer) begin
        e_valid_q <= 1'b1;
      end else if (fire) begin
        e_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        pc_q       <= next_pc;
        index_q    <= index_d;
        sp_q       <= sp_d;
        dt_q       <= dt_d;
        st_q       <= st_d;
        vf_q       <= vf_d;
        lw_valid_q <= rw && (x != 4'hF);
        if (rw && x == 4'h0) begin
          v0_q <= rval;
        end
        if (rw && x != 4'hF) begin
          reg_vld_q[x] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      e_uop_q   <= head_i.uop;
      rdx_q     <= regs_mem[hx];
      rdy_q     <= regs_mem[hy];
      rdx_vld_q <= reg_vld_q[hx];
      rdy_vld_q <= reg_vld_q[hy];
    end
    if (fire) begin
      out_res_q <= res;
      lw_idx_q  <= x;
      lw_val_q  <= rval;
      if (rw && x != 4'hF) begin
        regs_mem[x] <= rval;
      end
    end
  end

  // return stack with registered top of stack
  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (stk_push) begin
        stk_mem[sp_q[IDX_W-1:0]] <= pc_q;
        tos_q <= pc_q;
      end else begin
        tos_q <= stk_mem[sp_m1[IDX_W-1:0]];
      end
    end
  end

  `BRV_ASSERT(a_sp_range, sp_q <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
  `BRV_ASSERT_NEXT(a_call_push, fire && stk_push,
                   tos_q == $past(pc_q) && sp_q == $past(sp_q) + SP_W'(1),
                   "call did not push pc")
  `BRV_ASSERT_NEXT(a_ret_target, fire && stk_pop, pc_q == $past(tos_q) + 12'd2,
                   "return went to wrong address")
  `BRV_ASSERT_NEXT(a_stack_err_hold, fire && res.status == ST_STACK,
                   sp_q == $past(sp_q) && pc_q == $past(pc_q) + 12'd2,
                   "stack error changed stack")

endmodule

`default_nettype wire
